// ----- hdl/hex_record_checksum_checker_unit_defines.svh -----
// Assertion macros shared by the record checksum checker modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef HEX_RECORD_CHECKSUM_CHECKER_UNIT_DEFINES_SVH
`define HEX_RECORD_CHECKSUM_CHECKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRCC_ASSERT_SAME(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRCC_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- hdl/hrcc_pkg.sv -----
// Package for the record checksum checker: widths, character codes, status codes,
// the line summary type and the hex digit decoder. No dependencies.
`default_nettype none

package hrcc_pkg;

	localparam int unsigned POS_W = 8;
	localparam logic [POS_W-1:0] MAX_LINE_CHARS = 8'd128;
	localparam logic [POS_W-1:0] MIN_LINE_CHARS = 8'd3;
	localparam logic [POS_W-1:0] TYPE_POS = 8'd8;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_FINAL_TYPE = 8'h35;
	localparam logic [1:0] RETRY_LIMIT_RESET = 2'd2;
	localparam int unsigned OUT_W = 16;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_RESEND = 2'd1,
		ST_ABORT = 2'd2,
		ST_FINAL = 2'd3
	} line_status_t;

	typedef struct packed {
		logic       good;
		logic       is_final;
		logic [7:0] expected;
	} line_sum_t;

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/hrcc_line_acc.sv -----
// Per-line accumulator: character position, byte assembly, running sum and type digit.
// Depends on hrcc_pkg.
`default_nettype none

module hrcc_line_acc
	import hrcc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_char,
	output line_sum_t       line_sum
);

	logic [POS_W-1:0] pos_q;
	logic [3:0]       nib_q;
	logic [7:0]       sum_q;
	logic [7:0]       last_q;
	logic [7:0]       prev_q;
	logic [7:0]       type_q;
	logic [3:0]       dv;
	logic [7:0]       byte_val;

	assign dv = digit_value(rx_char);
	assign byte_val = {nib_q, dv};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			nib_q <= '0;
			sum_q <= '0;
			last_q <= '0;
			prev_q <= '0;
			type_q <= '0;
		end else if (step) begin
			if (rx_char == CHAR_LF) begin
				pos_q <= '0;
				nib_q <= '0;
				sum_q <= '0;
				last_q <= '0;
				prev_q <= '0;
				type_q <= '0;
			end else if (pos_q < MAX_LINE_CHARS) begin
				if (pos_q == TYPE_POS) begin
					type_q <= rx_char;
				end
				if (pos_q != '0) begin
					if (pos_q[0]) begin
						nib_q <= dv;
					end else begin
						prev_q <= sum_q;
						sum_q <= sum_q + byte_val;
						last_q <= byte_val;
					end
				end
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_comb begin
		line_sum.expected = 8'(8'd0 - prev_q);
		line_sum.good = (pos_q < MAX_LINE_CHARS) && (pos_q >= MIN_LINE_CHARS) && pos_q[0]
			&& (line_sum.expected == last_q);
		line_sum.is_final = (type_q == CHAR_FINAL_TYPE);
	end

endmodule

`default_nettype wire

// ----- hdl/hrcc_verdict.sv -----
// Verdict logic and result register: retry count, erase flag, halt and output item.
// Depends on hrcc_pkg and the shared assertion macros.
`default_nettype none
`include "hex_record_checksum_checker_unit_defines.svh"

module hrcc_verdict
	import hrcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             eol_step,
	input  line_sum_t             line_sum,
	input  wire logic [1:0]       retry_limit,
	output logic                  halted,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata
);

	logic [1:0]   retry_q;
	logic         erase_done_q;
	logic         halted_q;
	logic         valid_q;
	line_status_t status_q;
	logic         erase_q;
	logic [7:0]   expected_q;
	line_status_t status_d;
	logic [1:0]   retry_d;
	logic         halt_d;

	always_comb begin
		status_d = ST_GOOD;
		retry_d = retry_q;
		halt_d = 1'b0;
		if (line_sum.good) begin
			retry_d = '0;
			if (line_sum.is_final) begin
				status_d = ST_FINAL;
				halt_d = 1'b1;
			end
		end else if (retry_q < retry_limit) begin
			status_d = ST_RESEND;
			retry_d = retry_q + 1'b1;
		end else begin
			status_d = ST_ABORT;
			halt_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q <= '0;
			erase_done_q <= 1'b0;
			halted_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (eol_step) begin
				retry_q <= retry_d;
				erase_done_q <= 1'b1;
				halted_q <= halt_d;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eol_step) begin
			status_q <= status_d;
			erase_q <= ~erase_done_q;
			expected_q <= line_sum.expected;
		end
	end

	assign halted = halted_q;
	assign m_tvalid = valid_q;
	assign m_tdata = {5'd0, expected_q, erase_q, status_q};

	`HRCC_ASSERT_NEXT(a_halt_silent, halted_q && !valid_q, !valid_q,
		"result produced while halted")
	`HRCC_ASSERT_SAME(a_end_halts, valid_q && (status_q == ST_ABORT || status_q == ST_FINAL),
		halted_q, "final or abort result without halt")
	`HRCC_ASSERT_SAME(a_erase_once, valid_q && erase_q, erase_done_q,
		"erase request without erase flag set")
	`HRCC_ASSERT_NEXT(a_eol_result, eol_step, valid_q, "line end gave no result")

endmodule

`default_nettype wire

// ----- hdl/hex_record_checksum_checker_unit.sv -----
// Top level of the record checksum checker: input register, line accumulator,
// verdict stage and the retry limit register. Depends on hrcc_pkg and the two submodules.
`default_nettype none

// The block takes one character item per cycle on the s_ stream unless stalled, and gives
// one result item on the m_ stream for each line end. A character is held in the input
// register and then folded into the line state; from there a line end writes the result
// register. The only stall is a line end that meets a result not yet taken; other
// characters pass even while the result waits. After an aborted or final record all items
// are taken and dropped until reset. The retry limit is to be written on the cfg_ port
// only while no item is in flight, which the block does not enforce; it resets to two.

module hex_record_checksum_checker_unit
	import hrcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,   // [7:0] rx_char
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // [1:0] line_status, [2] erase_request,
	                                         // [10:3] expected_sum, rest zero
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_data   // [1:0] retry_limit
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic [1:0] retry_limit_q;
	logic       halted;
	logic       eol_s1;
	logic       wants_out;
	logic       fire_s1;
	line_sum_t  line_sum;

	assign eol_s1 = (char_s1 == CHAR_LF);
	assign wants_out = valid_s1 && eol_s1 && !halted;
	assign fire_s1 = valid_s1 && (!wants_out || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || fire_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			retry_limit_q <= RETRY_LIMIT_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (cfg_valid) begin
				retry_limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	hrcc_line_acc u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (fire_s1 && !halted),
		.rx_char  (char_s1),
		.line_sum (line_sum)
	);

	hrcc_verdict u_verdict (
		.clk         (clk),
		.arst_n      (arst_n),
		.eol_step    (fire_s1 && wants_out),
		.line_sum    (line_sum),
		.retry_limit (retry_limit_q),
		.halted      (halted),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

`default_nettype wire
